FILE: sv/assert_macros.svh
// Assertion macros for the RTL of the isolated black pixel fill unit.
// Depends on nothing; files that assert take it in by include.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// checked at every edge outside reset
`define IBPF_ASSERT(lbl, ck, rstn, prop, msg) \
    lbl: assert property (@(posedge ck) disable iff (!rstn) prop) else $error(msg);
// checked at every edge, reset included
`define IBPF_ASSERT_ALWAYS(lbl, ck, prop, msg) \
    lbl: assert property (@(posedge ck) prop) else $error(msg);
`else
`define IBPF_ASSERT(lbl, ck, rstn, prop, msg)
`define IBPF_ASSERT_ALWAYS(lbl, ck, prop, msg)
`endif
`endif

FILE: sv/ibpf_pkg.sv
// Package of the isolated black pixel fill unit: payload types, controller
// command/status structs, register indexes and small constant tables. No dependencies.
package ibpf_pkg;

    typedef struct packed {
        logic       cmd;
        logic [7:0] first_channel;
        logic [7:0] second_channel;
        logic [7:0] third_channel;
    } pix_item_t;

    typedef struct packed {
        logic [7:0] out_first;
        logic [7:0] out_second;
        logic [7:0] out_third;
        logic       was_filled;
        logic       frame_end;
    } res_item_t;

    localparam logic CMD_PIXEL = 1'b0;
    localparam logic CMD_DRAIN = 1'b1;

    localparam logic REG_IMAGE_WIDTH  = 1'b0;
    localparam logic REG_IMAGE_HEIGHT = 1'b1;

    localparam int WIDTH_BITS  = 11;
    localparam int HEIGHT_BITS = 16;
    localparam int KW          = 27;
    localparam int SUM_BITS    = 11;
    localparam int RECIP_BITS  = 17;
    localparam int PROD_BITS   = SUM_BITS + RECIP_BITS;

    localparam logic [WIDTH_BITS-1:0]  WIDTH_RESET  = 11'd640;
    localparam logic [HEIGHT_BITS-1:0] HEIGHT_RESET = 16'd480;

    typedef struct packed {
        logic accept;
        logic mark;
        logic cen_latch;
        logic nb_rd;
        logic nb_acc;
        logic div;
        logic out_load;
        logic store;
    } dp_cmd_t;

    typedef struct packed {
        logic is_pixel;
        logic emit;
        logic drain_ok;
        logic hole;
        logic nb_last;
        logic out_free;
    } dp_stat_t;

    // ceil(2^16 / n); exact for n*255 sums
    function automatic logic [RECIP_BITS-1:0] recip(input logic [3:0] cnt);
        logic [RECIP_BITS-1:0] r;
        unique case (cnt)
            4'd2:    r = 17'd32768;
            4'd3:    r = 17'd21846;
            4'd4:    r = 17'd16384;
            4'd5:    r = 17'd13108;
            4'd6:    r = 17'd10923;
            4'd7:    r = 17'd9363;
            4'd8:    r = 17'd8192;
            default: r = 17'd65536;
        endcase
        return r;
    endfunction

    // neighbor offsets {dr, dc} around the center, center skipped
    function automatic logic [3:0] nb_offs(input logic [2:0] idx);
        logic [3:0] o;
        unique case (idx)
            3'd0: o = {2'd0, 2'd0};
            3'd1: o = {2'd0, 2'd1};
            3'd2: o = {2'd0, 2'd2};
            3'd3: o = {2'd1, 2'd0};
            3'd4: o = {2'd1, 2'd2};
            3'd5: o = {2'd2, 2'd0};
            3'd6: o = {2'd2, 2'd1};
            3'd7: o = {2'd2, 2'd2};
            default: o = 4'd0;
        endcase
        return o;
    endfunction

    function automatic logic is_black(input logic [23:0] p);
        return p == 24'd0;
    endfunction

endpackage

FILE: sv/ibpf_ctrl.sv
// Sequencer of the isolated black pixel fill unit.
// Depends on ibpf_pkg for the command and status structs.
module ibpf_ctrl
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               pix_valid,
    input  logic               pix_cmd,
    input  ibpf_pkg::dp_stat_t stat,
    output logic               pix_stall,
    output ibpf_pkg::dp_cmd_t  cmd
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_MARK  = 3'd1;
    localparam logic [2:0] S_CEN   = 3'd2;
    localparam logic [2:0] S_NRD   = 3'd3;
    localparam logic [2:0] S_NACC  = 3'd4;
    localparam logic [2:0] S_DIV   = 3'd5;
    localparam logic [2:0] S_OUT   = 3'd6;
    localparam logic [2:0] S_STORE = 3'd7;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (pix_valid)
                begin
                    cmd.accept = 1'b1;
                    if (pix_cmd == ibpf_pkg::CMD_PIXEL || stat.drain_ok)
                        state_next = S_MARK;
                end
            end
            S_MARK:
            begin
                cmd.mark   = 1'b1;
                state_next = stat.emit ? S_CEN : S_STORE;
            end
            S_CEN:
            begin
                cmd.cen_latch = 1'b1;
                state_next    = stat.hole ? S_NRD : S_OUT;
            end
            S_NRD:
            begin
                cmd.nb_rd  = 1'b1;
                state_next = S_NACC;
            end
            S_NACC:
            begin
                cmd.nb_acc = 1'b1;
                state_next = stat.nb_last ? S_DIV : S_NRD;
            end
            S_DIV:
            begin
                cmd.div    = 1'b1;
                state_next = S_OUT;
            end
            S_OUT:
            begin
                if (stat.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = stat.is_pixel ? S_STORE : S_IDLE;
                end
            end
            S_STORE:
            begin
                cmd.store  = 1'b1;
                state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    assign pix_stall = (state_reg != S_IDLE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

endmodule

FILE: sv/ibpf_dp.sv
// Datapath of the isolated black pixel fill unit: three-row ring memory,
// hole marks, stream counters, neighbor accumulator, divider and output register.
// Depends on ibpf_pkg.
module ibpf_dp #(
    parameter int MAX_WIDTH = 1024
)
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_restart,
    input  logic [ibpf_pkg::WIDTH_BITS-1:0]     image_width,
    input  logic [ibpf_pkg::HEIGHT_BITS-1:0]    image_height,
    input  ibpf_pkg::pix_item_t                 pix,
    input  ibpf_pkg::dp_cmd_t                   cmd,
    output ibpf_pkg::dp_stat_t                  stat,
    output ibpf_pkg::res_item_t                 res,
    output logic                                res_valid,
    input  logic                                res_stall
);

    localparam int CW      = $clog2(MAX_WIDTH + 1);
    localparam int DEPTH   = 3 * MAX_WIDTH;
    localparam int AW      = $clog2(DEPTH);
    localparam int XW      = (CW > ibpf_pkg::WIDTH_BITS) ? CW : ibpf_pkg::WIDTH_BITS;
    localparam int HW      = ibpf_pkg::HEIGHT_BITS;
    localparam int KW      = CW + HW;
    localparam int SW      = ibpf_pkg::SUM_BITS;
    localparam int PW      = ibpf_pkg::PROD_BITS;
    localparam int RECIP_W = ibpf_pkg::RECIP_BITS;

    logic [23:0] pix_mem [DEPTH];
    logic        mark_mem [DEPTH];

    ibpf_pkg::pix_item_t item_reg;
    ibpf_pkg::res_item_t res_reg;
    logic          res_valid_reg;
    logic [CW-1:0] in_col_reg, out_col_reg;
    logic [HW-1:0] in_row_reg, out_row_reg;
    logic [1:0]    in_rm_reg, out_rm_reg;
    logic [KW-1:0] k_reg;
    logic [23:0]   last1_reg, last2_reg, cen_pix_reg, pix_q_reg;
    logic          mark_q_reg, filled_reg;
    logic [2:0]    idx_reg;
    logic [SW-1:0] s0_reg, s1_reg, s2_reg;
    logic [3:0]    cnt_reg;
    logic [7:0]    q0_reg, q1_reg, q2_reg;

    logic [XW-1:0] wx;
    logic [CW-1:0] w_eff;
    logic [HW-1:0] h_eff;
    logic [23:0]   incoming;
    logic          mark_val, mark_we, interior, restart;
    logic [AW-1:0] mark_addr, store_addr, rd_addr, cen_addr, nb_addr;
    logic [3:0]    offs;
    logic [1:0]    rm_prev, rm_next, nb_rm;
    logic [CW-1:0] nb_col, in_col_inc, out_col_inc;
    logic [RECIP_W-1:0] rc;
    logic [PW-1:0] p0, p1, p2;
    logic          frame_end;

    function automatic logic [AW-1:0] slot(input logic [1:0] rm, input logic [CW-1:0] col);
        logic [AW-1:0] base;
        base = (rm == 2'd0) ? AW'(0) : ((rm == 2'd1) ? AW'(MAX_WIDTH) : AW'(2 * MAX_WIDTH));
        return base + AW'(col);
    endfunction

    // effective frame size
    always_comb
    begin
        wx = XW'(image_width);
        if (wx == '0)
            w_eff = CW'(1);
        else if (wx > XW'(MAX_WIDTH))
            w_eff = CW'(MAX_WIDTH);
        else
            w_eff = CW'(wx);
        h_eff = (image_height == '0) ? HW'(1) : image_height;
    end

    assign incoming = {item_reg.third_channel, item_reg.second_channel, item_reg.first_channel};

    // hole test of the pixel left of the incoming one
    assign mark_val = (in_col_reg >= CW'(2)) && (in_col_reg < w_eff) &&
                      (in_row_reg != '0) &&
                      ({1'b0, in_row_reg} + (HW+1)'(1) < {1'b0, h_eff}) &&
                      ibpf_pkg::is_black(last1_reg) && !ibpf_pkg::is_black(last2_reg) &&
                      !ibpf_pkg::is_black(incoming);
    assign mark_we   = cmd.mark && (item_reg.cmd == ibpf_pkg::CMD_PIXEL) && (in_col_reg != '0);
    assign mark_addr = slot(in_rm_reg, in_col_reg - CW'(1));
    assign store_addr = slot(in_rm_reg, in_col_reg);

    // neighbor addressing
    assign offs    = ibpf_pkg::nb_offs(idx_reg);
    assign rm_prev = (out_rm_reg == 2'd0) ? 2'd2 : out_rm_reg - 2'd1;
    assign rm_next = (out_rm_reg == 2'd2) ? 2'd0 : out_rm_reg + 2'd1;
    assign nb_rm   = (offs[3:2] == 2'd0) ? rm_prev : ((offs[3:2] == 2'd1) ? out_rm_reg : rm_next);
    assign nb_col  = out_col_reg + CW'(offs[1:0]) - CW'(1);
    assign nb_addr = slot(nb_rm, nb_col);
    assign cen_addr = slot(out_rm_reg, out_col_reg);
    assign rd_addr = cmd.nb_rd ? nb_addr : cen_addr;

    assign interior = (out_row_reg != '0) &&
                      ({1'b0, out_row_reg} + (HW+1)'(1) < {1'b0, h_eff}) &&
                      (out_col_reg != '0) &&
                      ({1'b0, out_col_reg} + (CW+1)'(1) < {1'b0, w_eff});

    assign frame_end = (out_row_reg == h_eff - HW'(1)) && (out_col_reg == w_eff - CW'(1));

    assign rc = ibpf_pkg::recip(cnt_reg);
    assign p0 = PW'(s0_reg) * PW'(rc);
    assign p1 = PW'(s1_reg) * PW'(rc);
    assign p2 = PW'(s2_reg) * PW'(rc);

    assign in_col_inc  = in_col_reg + CW'(1);
    assign out_col_inc = out_col_reg + CW'(1);

    assign restart = cfg_restart ||
                     (cmd.accept && (pix.cmd == ibpf_pkg::CMD_PIXEL) && (in_row_reg >= h_eff));

    always_comb
    begin
        stat.is_pixel = (item_reg.cmd == ibpf_pkg::CMD_PIXEL);
        stat.drain_ok = (in_row_reg >= h_eff) && (out_row_reg < h_eff);
        stat.emit     = stat.is_pixel ?
                        ((k_reg >= KW'(w_eff) + KW'(2)) && (out_row_reg < h_eff)) :
                        stat.drain_ok;
        stat.hole     = interior && mark_q_reg;
        stat.nb_last  = (idx_reg == 3'd7);
        stat.out_free = !res_valid_reg || !res_stall;
    end

    // ring memory: one write, one registered read per cycle
    always_ff @(posedge clk)
    begin
        if (mark_we)
            mark_mem[mark_addr] <= mark_val;
        else if (cmd.store)
        begin
            mark_mem[store_addr] <= 1'b0;
            pix_mem[store_addr]  <= incoming;
        end
        pix_q_reg  <= pix_mem[rd_addr];
        mark_q_reg <= mark_mem[rd_addr];
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.accept)
            item_reg <= pix;
        if (cmd.store)
        begin
            last2_reg <= last1_reg;
            last1_reg <= incoming;
        end
        if (cmd.cen_latch)
        begin
            cen_pix_reg <= pix_q_reg;
            filled_reg  <= 1'b0;
            idx_reg     <= 3'd0;
            cnt_reg     <= 4'd0;
            s0_reg      <= '0;
            s1_reg      <= '0;
            s2_reg      <= '0;
        end
        if (cmd.nb_acc)
        begin
            idx_reg <= idx_reg + 3'd1;
            if (!mark_q_reg)
            begin
                s0_reg  <= s0_reg + SW'(pix_q_reg[7:0]);
                s1_reg  <= s1_reg + SW'(pix_q_reg[15:8]);
                s2_reg  <= s2_reg + SW'(pix_q_reg[23:16]);
                cnt_reg <= cnt_reg + 4'd1;
            end
        end
        if (cmd.div)
        begin
            q0_reg     <= p0[23:16];
            q1_reg     <= p1[23:16];
            q2_reg     <= p2[23:16];
            filled_reg <= (cnt_reg != 4'd0);
        end
        if (cmd.out_load)
        begin
            res_reg.out_first  <= filled_reg ? q0_reg : cen_pix_reg[7:0];
            res_reg.out_second <= filled_reg ? q1_reg : cen_pix_reg[15:8];
            res_reg.out_third  <= filled_reg ? q2_reg : cen_pix_reg[23:16];
            res_reg.was_filled <= filled_reg;
            res_reg.frame_end  <= frame_end;
        end
    end

    // stream counters and output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_col_reg    <= '0;
            in_row_reg    <= '0;
            in_rm_reg     <= 2'd0;
            k_reg         <= '0;
            out_col_reg   <= '0;
            out_row_reg   <= '0;
            out_rm_reg    <= 2'd0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.out_load)
                res_valid_reg <= 1'b1;
            else if (!res_stall)
                res_valid_reg <= 1'b0;

            if (restart)
            begin
                in_col_reg  <= '0;
                in_row_reg  <= '0;
                in_rm_reg   <= 2'd0;
                k_reg       <= '0;
                out_col_reg <= '0;
                out_row_reg <= '0;
                out_rm_reg  <= 2'd0;
            end
            else
            begin
                if (cmd.store)
                begin
                    k_reg <= k_reg + KW'(1);
                    if (in_col_inc >= w_eff)
                    begin
                        in_col_reg <= '0;
                        in_row_reg <= in_row_reg + HW'(1);
                        in_rm_reg  <= (in_rm_reg == 2'd2) ? 2'd0 : in_rm_reg + 2'd1;
                    end
                    else
                        in_col_reg <= in_col_inc;
                end
                if (cmd.out_load)
                begin
                    if (out_col_inc >= w_eff)
                    begin
                        out_col_reg <= '0;
                        out_row_reg <= out_row_reg + HW'(1);
                        out_rm_reg  <= rm_next;
                    end
                    else
                        out_col_reg <= out_col_inc;
                end
            end
        end
    end

    assign res       = res_reg;
    assign res_valid = res_valid_reg;

endmodule

FILE: sv/isolated_black_pixel_fill_unit.sv
// Isolated black pixel fill unit: top level with configuration registers,
// sequencer and datapath. Depends on ibpf_pkg, ibpf_ctrl, ibpf_dp, assert_macros.svh.
//
// Usage:
//  - Input channel pix/pix_valid/pix_stall carries one transaction per pixel
//    (cmd = pixel) in raster order, or a drain tick (cmd = drain).
//  - Output channel res/res_valid/res_stall gives the frame back in raster
//    order, holes replaced by the average of their non-hole neighbors.
//  - The output lags the input by one row plus two pixels; after the last
//    pixel of a frame, drain ticks flush the remaining pixels one each.
//  - One transaction at a time: a pixel that emits nothing is marked and stored,
//    a pass-through emit also latches the center and loads the output, a filled
//    hole reads its eight neighbors over the single memory read port, a read and
//    an accumulate step each, then divides. A drain tick skips the store; one with nothing to emit is only taken.
//  - The result sits in an output register; the next input transaction is
//    taken while it waits. A stalled receiver holds the sequencer only when
//    a new result must be loaded.
//  - Reset clears the counters and restores width 640 and height 480; the
//    ring memory is not cleared. Any register write restarts the stream.
//  - Registers: image_width at 0x0, image_height at 0x4; pready is always 1.
module isolated_black_pixel_fill_unit #(
    parameter int MAX_WIDTH = 1024
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  ibpf_pkg::pix_item_t pix,
    input  logic                pix_valid,
    output logic                pix_stall,
    output ibpf_pkg::res_item_t res,
    output logic                res_valid,
    input  logic                res_stall,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [2:0]          paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready
);

`include "assert_macros.svh"

    logic [ibpf_pkg::WIDTH_BITS-1:0]  width_reg;
    logic [ibpf_pkg::HEIGHT_BITS-1:0] height_reg;
    logic                             cfg_wr;
    ibpf_pkg::dp_cmd_t                dp_cmd;
    ibpf_pkg::dp_stat_t               dp_stat;

    // register write completes in the access phase
    assign cfg_wr = psel && penable && pwrite && pready;
    assign pready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= ibpf_pkg::WIDTH_RESET;
            height_reg <= ibpf_pkg::HEIGHT_RESET;
        end
        else if (cfg_wr)
        begin
            if (paddr[2] == ibpf_pkg::REG_IMAGE_WIDTH)
                width_reg <= pwdata[ibpf_pkg::WIDTH_BITS-1:0];
            else
                height_reg <= pwdata[ibpf_pkg::HEIGHT_BITS-1:0];
        end
    end

    assign prdata = (paddr[2] == ibpf_pkg::REG_IMAGE_WIDTH) ? 32'(width_reg) : 32'(height_reg);

    ibpf_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .pix_valid (pix_valid),
        .pix_cmd   (pix.cmd),
        .stat      (dp_stat),
        .pix_stall (pix_stall),
        .cmd       (dp_cmd)
    );

    ibpf_dp #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_dp
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_restart  (cfg_wr),
        .image_width  (width_reg),
        .image_height (height_reg),
        .pix          (pix),
        .cmd          (dp_cmd),
        .stat         (dp_stat),
        .res          (res),
        .res_valid    (res_valid),
        .res_stall    (res_stall)
    );

    // the last pixel of a frame is a border pixel and is never filled
    `IBPF_ASSERT(a_fill_not_last, clk, rst_n, res_valid |-> !(res.was_filled && res.frame_end), "filled pixel flagged as frame end")
    // a new result never overwrites one still waiting
    `IBPF_ASSERT(a_load_free, clk, rst_n, dp_cmd.out_load |-> (!res_valid || !res_stall), "result overwritten while stalled")
    // while the input is open the datapath does no per-item work
    `IBPF_ASSERT_ALWAYS(a_idle_quiet, clk, !pix_stall |-> !(dp_cmd.store || dp_cmd.out_load || dp_cmd.div), "datapath busy while input open")

endmodule

FILE: test/testbench.sv
// Testbench for isolated_black_pixel_fill_unit: directed frames, size extremes,
// backpressure and random frames, checked against an in-bench predictor.
// Depends on ibpf_pkg and the RTL of isolated_black_pixel_fill_unit.
`timescale 1ns / 1ps

module testbench;

    localparam int RING_W     = 1024;  // must match the MAX_WIDTH of the DUT
    localparam int IDLE_LIMIT = 4000;  // cycles with no transaction before giving up
    localparam int SETTLE     = 30;    // longest single-item latency plus margin
    localparam int ITEM_GOAL  = 850;   // input transactions over the whole run

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    ibpf_pkg::pix_item_t pix = '0;
    logic                pix_valid = 1'b0;
    logic                pix_stall;
    ibpf_pkg::res_item_t res;
    logic                res_valid;
    logic                res_stall = 1'b0;
    logic                psel = 1'b0;
    logic                penable = 1'b0;
    logic                pwrite = 1'b0;
    logic [2:0]          paddr = '0;
    logic [31:0]         pwdata = '0;
    logic [31:0]         prdata;
    logic                pready;

    isolated_black_pixel_fill_unit #(.MAX_WIDTH(RING_W)) u_dut (
        .clk(clk), .rst_n(rst_n),
        .pix(pix), .pix_valid(pix_valid), .pix_stall(pix_stall),
        .res(res), .res_valid(res_valid), .res_stall(res_stall),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // ---------------------------------------------------------------
    // Fill predictor: own copy of the three-row ring, hole flags,
    // size registers and stream counters.
    // ---------------------------------------------------------------
    logic [23:0]      ring_px   [0:3*RING_W-1];
    bit               ring_hole [0:3*RING_W-1];
    logic [10:0]      width_reg;
    logic [15:0]      height_reg;
    int unsigned      in_col, in_row, out_idx;

    ibpf_pkg::res_item_t expected_pixels[$];
    int               mismatches = 0;
    int               n_pixels = 0, n_drains = 0, n_results = 0, n_filled = 0;

    // idling controls of the sender and the receiver
    bit               sender_idles = 1'b1;
    int               stall_pct = 20;
    int               hold_req = 0;

    function automatic int unsigned eff_w();
        if (width_reg == 0) return 1;
        if (width_reg > RING_W) return RING_W;
        return width_reg;
    endfunction

    function automatic int unsigned eff_h();
        return (height_reg == 0) ? 1 : height_reg;
    endfunction

    function automatic int unsigned ring_slot(int unsigned r, int unsigned c);
        if (c >= RING_W) c = RING_W - 1;
        return (r % 3) * RING_W + c;
    endfunction

    // Output the pixel at out_idx, averaging it if it is a marked hole.
    function automatic ibpf_pkg::res_item_t emit_pixel();
        int unsigned w, h, r, c, s, cnt;
        int unsigned sum0, sum1, sum2;
        logic [23:0] p, q;
        ibpf_pkg::res_item_t o;
        w = eff_w();
        h = eff_h();
        r = out_idx / w;
        c = out_idx % w;
        p = ring_px[ring_slot(r, c)];
        o.was_filled = 1'b0;
        if (r >= 1 && r + 1 < h && c >= 1 && c + 1 < w && ring_hole[ring_slot(r, c)])
        begin
            sum0 = 0; sum1 = 0; sum2 = 0; cnt = 0;
            for (int dr = 0; dr < 3; dr++)
                for (int dc = 0; dc < 3; dc++)
                begin
                    if (dr == 1 && dc == 1) continue;
                    s = ring_slot(r - 1 + dr, c - 1 + dc);
                    if (ring_hole[s]) continue;
                    q = ring_px[s];
                    sum0 += q[7:0];
                    sum1 += q[15:8];
                    sum2 += q[23:16];
                    cnt++;
                end
            if (cnt != 0)
            begin
                p = {8'(sum2 / cnt), 8'(sum1 / cnt), 8'(sum0 / cnt)};
                o.was_filled = 1'b1;
            end
        end
        o.out_first  = p[7:0];
        o.out_second = p[15:8];
        o.out_third  = p[23:16];
        o.frame_end  = (longint'(out_idx) + 1 == longint'(w) * h);
        out_idx++;
        return o;
    endfunction

    function automatic bit predict_fill(ibpf_pkg::pix_item_t it,
                                        output ibpf_pkg::res_item_t o);
        int unsigned w, h, row, col;
        longint      total, k;
        logic [23:0] incoming;
        bit          got;
        w = eff_w();
        h = eff_h();
        total = longint'(w) * h;
        got = 1'b0;
        o = '0;
        if (it.cmd == ibpf_pkg::CMD_DRAIN)
        begin
            if (in_row >= h && out_idx < total)
            begin
                o = emit_pixel();
                got = 1'b1;
            end
            return got;
        end
        // a pixel after a complete frame opens the next one
        if (in_row >= h || in_col >= w)
        begin
            in_row = 0; in_col = 0; out_idx = 0;
        end
        row = in_row;
        col = in_col;
        incoming = {it.third_channel, it.second_channel, it.first_channel};
        // the incoming pixel settles the hole flag of its left neighbor
        if (col >= 1)
        begin
            bit mark;
            mark = 1'b0;
            if (col >= 2 && col < w && row >= 1 && row + 1 < h)
                mark = (ring_px[ring_slot(row, col - 1)] == 0)
                    && (ring_px[ring_slot(row, col - 2)] != 0) && (incoming != 0);
            ring_hole[ring_slot(row, col - 1)] = mark;
        end
        k = longint'(row) * w + col;
        if (k >= longint'(w) + 2 && out_idx < total)
        begin
            o = emit_pixel();
            got = 1'b1;
        end
        ring_px[ring_slot(row, col)] = incoming;
        ring_hole[ring_slot(row, col)] = 1'b0;
        col++;
        if (col >= w)
        begin
            col = 0;
            row++;
        end
        in_col = col;
        in_row = row;
        return got;
    endfunction

    // ---------------------------------------------------------------
    // Checking
    // ---------------------------------------------------------------
    task automatic report_mismatch(string what);
        $display("[%0t] MISMATCH: %s", $realtime, what);
        mismatches++;
    endtask

    always @(posedge clk)
    begin
        if (rst_n && res_valid && !res_stall)
        begin
            if (expected_pixels.size() == 0)
                report_mismatch($sformatf("unexpected result %p", res));
            else
            begin
                ibpf_pkg::res_item_t e;
                e = expected_pixels.pop_front();
                n_results++;
                if (e.was_filled) n_filled++;
                if (res.out_first !== e.out_first)
                    report_mismatch($sformatf("out_first %0d, want %0d",
                        res.out_first, e.out_first));
                if (res.out_second !== e.out_second)
                    report_mismatch($sformatf("out_second %0d, want %0d",
                        res.out_second, e.out_second));
                if (res.out_third !== e.out_third)
                    report_mismatch($sformatf("out_third %0d, want %0d",
                        res.out_third, e.out_third));
                if (res.was_filled !== e.was_filled)
                    report_mismatch($sformatf("was_filled %0b, want %0b",
                        res.was_filled, e.was_filled));
                if (res.frame_end !== e.frame_end)
                    report_mismatch($sformatf("frame_end %0b, want %0b",
                        res.frame_end, e.frame_end));
            end
        end
    end

    // Receiver: random stall, occasional long holds, and forced holds on request.
    int hold_left = 0;
    always @(posedge clk)
    begin
        if (hold_req > 0)
        begin
            hold_left = hold_req;
            hold_req = 0;
        end
        else if (hold_left == 0 && stall_pct > 0 && $urandom_range(149) == 0)
            hold_left = $urandom_range(40, 8);
        if (hold_left > 0)
        begin
            hold_left--;
            res_stall <= 1'b1;
        end
        else
            res_stall <= ($urandom_range(99) < stall_pct);
    end

    // Watchdog: cycles in which no transaction of any kind happens.
    int quiet_cycles = 0;
    always @(posedge clk)
    begin
        if ((pix_valid && !pix_stall) || (res_valid && !res_stall) || (psel && penable)
            || !rst_n)
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= IDLE_LIMIT)
        begin
            $display("Timeout: %0d cycles without a transaction", IDLE_LIMIT);
            $display("Mismatches found");
            $finish;
        end
    end

    // ---------------------------------------------------------------
    // Sender side
    // ---------------------------------------------------------------
    function automatic int gap_len();
        int x;
        if (!sender_idles) return 0;
        x = $urandom_range(99);
        if (x < 60) return 0;
        if (x < 92) return $urandom_range(3, 1);
        return $urandom_range(40, 8);
    endfunction

    // Offer one transaction; valid stays high only if the next send follows at once.
    task automatic send_item(ibpf_pkg::pix_item_t it);
        ibpf_pkg::res_item_t o;
        int        g;
        pix <= it;
        pix_valid <= 1'b1;
        do @(posedge clk); while (pix_stall);
        if (predict_fill(it, o)) expected_pixels.push_back(o);
        if (it.cmd == ibpf_pkg::CMD_DRAIN) n_drains++; else n_pixels++;
        g = gap_len();
        if (g > 0)
        begin
            pix_valid <= 1'b0;
            repeat (g) @(posedge clk);
        end
    endtask

    task automatic send_px(logic [23:0] p);
        send_item('{cmd: ibpf_pkg::CMD_PIXEL, first_channel: p[7:0],
                    second_channel: p[15:8], third_channel: p[23:16]});
    endtask

    task automatic send_drain();
        send_item('{cmd: ibpf_pkg::CMD_DRAIN, first_channel: 8'($urandom),
                    second_channel: 8'($urandom), third_channel: 8'($urandom)});
    endtask

    // Pause the sender until every expected result has come out.
    task automatic wait_results();
        pix_valid <= 1'b0;
        @(posedge clk);
        while (expected_pixels.size() != 0) @(posedge clk);
    endtask

    // Block idle: nothing expected, and time for a silent item to finish.
    task automatic wait_idle();
        wait_results();
        repeat (SETTLE) @(posedge clk);
    endtask

    // ---------------------------------------------------------------
    // Register port
    // ---------------------------------------------------------------
    task automatic reg_write(logic idx, logic [31:0] val);
        psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
        paddr <= {idx, 2'b00}; pwdata <= val;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
        if (idx == ibpf_pkg::REG_IMAGE_WIDTH) width_reg = val[10:0];
        else height_reg = val[15:0];
        in_col = 0; in_row = 0; out_idx = 0;
        @(posedge clk);
    endtask

    task automatic reg_check(logic idx, logic [31:0] want);
        psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b0; paddr <= {idx, 2'b00};
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        if (prdata !== want)
            report_mismatch($sformatf("register %0d reads %0h, want %0h", idx, prdata, want));
        psel <= 1'b0; penable <= 1'b0;
        @(posedge clk);
    endtask

    task automatic set_size(int unsigned w, int unsigned h);
        wait_idle();
        reg_write(ibpf_pkg::REG_IMAGE_WIDTH, w);
        reg_write(ibpf_pkg::REG_IMAGE_HEIGHT, h);
        reg_check(ibpf_pkg::REG_IMAGE_WIDTH, {21'd0, width_reg});
        reg_check(ibpf_pkg::REG_IMAGE_HEIGHT, {16'd0, height_reg});
    endtask

    // Random pixel: black with the given percentage, else any value.
    function automatic logic [23:0] rand_px(int black_pct);
        int x;
        if ($urandom_range(99) < black_pct) return 24'd0;
        x = $urandom_range(9);
        if (x == 0) return 24'hFFFFFF;
        return 24'($urandom);
    endfunction

    // One frame of pixels, optional stray drains inside, then a number of drains.
    task automatic run_frame(int black_pct, bit stray_drains, int drains);
        int total;
        total = eff_w() * eff_h();
        for (int i = 0; i < total; i++)
        begin
            if (stray_drains && $urandom_range(19) == 0) send_drain();
            send_px(rand_px(black_pct));
        end
        repeat (drains) send_drain();
    endtask

    // ---------------------------------------------------------------
    // Tests
    // ---------------------------------------------------------------
    task automatic test_reset_values();
        reg_check(ibpf_pkg::REG_IMAGE_WIDTH, 32'd640);
        reg_check(ibpf_pkg::REG_IMAGE_HEIGHT, 32'd480);
        // one row plus six pixels with the reset size, enough to see the first outputs
        for (int i = 0; i < 646; i++) send_px(rand_px(30));
    endtask

    task automatic test_holes();
        // 5x4 frame: isolated holes, diagonally touching holes, black runs,
        // black on the border, full-scale neighbors
        logic [23:0] pic [0:19];
        pic = '{24'h0A0B0C, 24'h000000, 24'hFFFFFF, 24'h102030, 24'h000000,
                24'hFFFFFF, 24'h000000, 24'h0000FF, 24'h010101, 24'hFF0000,
                24'h00FF00, 24'h808080, 24'h000000, 24'h7F7F7F, 24'h000000,
                24'h000000, 24'hFFFFFF, 24'h000001, 24'h000000, 24'hFFFFFF};
        set_size(5, 4);
        for (int i = 0; i < 20; i++)
        begin
            if (i == 3) send_drain();  // drain before the frame is complete: no output
            send_px(pic[i]);
        end
        repeat (9) send_drain();       // flush the tail plus two with nothing pending
    endtask

    task automatic test_degenerate_sizes();
        set_size(0, 3);                // width 0 runs as 1
        run_frame(50, 0, 4);
        set_size(2, 0);                // height 0 runs as 1
        run_frame(50, 0, 3);
        set_size(1, 1);
        run_frame(50, 0, 2);
    endtask

    task automatic test_large_sizes();
        set_size(2047, 65535);         // full register range, cut short by the next write
        for (int i = 0; i < 30; i++) send_px(rand_px(30));
    endtask

    task automatic test_backpressure();
        set_size(6, 4);
        sender_idles = 1'b0;
        hold_req = 300;                // receiver holds off while pixels keep coming
        run_frame(40, 0, 8);
        // sender pauses mid-frame until the block has caught up
        for (int i = 0; i < 14; i++) send_px(rand_px(40));
        wait_results();
        for (int i = 0; i < 10; i++) send_px(rand_px(40));
        repeat (8) send_drain();
        sender_idles = 1'b1;
    endtask

    task automatic test_random_frames();
        int w, h, x;
        while (n_pixels + n_drains < ITEM_GOAL)
        begin
            x = $urandom_range(9);
            if (x < 4)
            begin
                w = ($urandom_range(9) == 0) ? $urandom_range(2, 1) : $urandom_range(12, 3);
                h = $urandom_range(6, 1);
                set_size(w, h);
            end
            // phases with and without idling on both sides
            sender_idles = ($urandom_range(3) != 0);
            stall_pct = ($urandom_range(3) == 0) ? 0 : $urandom_range(60, 5);
            if ($urandom_range(4) == 0)
                run_frame($urandom_range(60, 10), 1'b1, $urandom_range(eff_w()));
            else
                run_frame($urandom_range(60, 10), $urandom_range(1), eff_w() + 2 +
                          $urandom_range(2));
        end
        stall_pct = 20;
        sender_idles = 1'b1;
    endtask

    initial
    begin
        for (int i = 0; i < 3 * RING_W; i++)
        begin
            ring_px[i] = '0;
            ring_hole[i] = 1'b0;
        end
        width_reg = ibpf_pkg::WIDTH_RESET;
        height_reg = ibpf_pkg::HEIGHT_RESET;
        in_col = 0; in_row = 0; out_idx = 0;

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_values();
        test_holes();
        test_degenerate_sizes();
        test_large_sizes();
        test_backpressure();
        test_random_frames();

        wait_idle();
        $display("Covered %0d pixels and %0d drain ticks; %0d pixels out, %0d holes filled.",
                 n_pixels, n_drains, n_results, n_filled);
        if (mismatches == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
